[hdl/dcq_pkg.sv]
package dcq_pkg;

	// default configuration
	localparam int CAPACITY_DEF   = 16;
	localparam int COORD_BITS_DEF = 16;

	// width of the entry count result field
	localparam int COUNT_OUT_BITS = 5;

	// item codes on the mode field
	localparam logic MODE_ADD = 1'b0;
	localparam logic MODE_GET = 1'b1;

	// status of the evaluation pipeline's last stage
	typedef struct packed {
		logic valid;
		logic hit;
	} eval_t;

endpackage

[hdl/dirty_rect_coalescing_queue.sv]
// channel | signals                                      | moves
// --------+----------------------------------------------+----------------------------------
// req     | req_valid req_ready mode in_left .. in_bottom| one add or get item
// rsp     | rsp_valid rsp_ready out_left .. entry_count  | one result item per request item
//
// a get goes through S_GET_RD, S_GET_WB and S_FINISH to the result (only S_FINISH on an empty store)
// an add scans the stored entries: the single read port of the
// rectangle memory first streams the entries through a 3-stage area check, then on a
// merge the later entries are moved down one per cycle
// reset clears the count, head pointer and all handshake state; memory contents are
// not cleared, only entries below the count are ever read
// a new item is taken while a result waits on rsp; a finished item waits in its last
// state until the result register is free
module dirty_rect_coalescing_queue #(
	parameter int CAPACITY   = dcq_pkg::CAPACITY_DEF,
	parameter int COORD_BITS = dcq_pkg::COORD_BITS_DEF
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         req_valid,
	output logic                         req_ready,
	input  logic                         mode,
	input  logic signed [COORD_BITS-1:0] in_left,
	input  logic signed [COORD_BITS-1:0] in_top,
	input  logic signed [COORD_BITS-1:0] in_right,
	input  logic signed [COORD_BITS-1:0] in_bottom,
	output logic                         rsp_valid,
	input  logic                         rsp_ready,
	output logic signed [COORD_BITS-1:0] out_left,
	output logic signed [COORD_BITS-1:0] out_top,
	output logic signed [COORD_BITS-1:0] out_right,
	output logic signed [COORD_BITS-1:0] out_bottom,
	output logic                         was_empty,
	output logic                         merged,
	output logic                         dropped,
	output logic [dcq_pkg::COUNT_OUT_BITS-1:0] entry_count
);
	import dcq_pkg::*;

	localparam int CB = COORD_BITS;
	localparam int RW = 4 * CB;                    // one stored rectangle
	localparam int IW = $clog2(CAPACITY);          // memory address
	localparam int CW = $clog2(CAPACITY + 1);      // count, 0 .. CAPACITY

	typedef enum logic [6:0] {
		S_IDLE   = 7'b0000001,
		S_GET_RD = 7'b0000010,
		S_GET_WB = 7'b0000100,
		S_SCAN   = 7'b0001000,
		S_SHIFT  = 7'b0010000,
		S_APPEND = 7'b0100000,
		S_FINISH = 7'b1000000
	} state_t;

	// logical position to memory address: the store is a ring starting at head
	function automatic logic [IW-1:0] phys(input logic [IW-1:0] head, input logic [CW-1:0] k);
		logic [CW:0] s;
		begin
			s = (CW + 1)'(head) + (CW + 1)'(k);
			if (s >= (CW + 1)'(CAPACITY)) begin
				s = s - (CW + 1)'(CAPACITY);
			end
			return IW'(s);
		end
	endfunction

	// control state
	state_t          state_q;
	logic [CW-1:0]   count_q;
	logic [IW-1:0]   head_q;
	logic [CW-1:0]   ptr_q;      // scan issue index, then close-up read index
	logic            rdv_s1;     // read data belongs to the scan
	logic [CW-1:0]   ridx_s1;
	logic            wv_s1;      // read data is a close-up move
	logic [IW-1:0]   wa_s1;

	// item payload and pending result
	logic [RW-1:0]   nw_q;
	logic [RW-1:0]   uni_q;
	logic [RW-1:0]   res_rect_q;
	logic            res_empty_q, res_merged_q, res_dropped_q;

	// result register
	logic            rsp_valid_q;
	logic [RW-1:0]   out_rect_q;
	logic            out_empty_q, out_merged_q, out_dropped_q;
	logic [COUNT_OUT_BITS-1:0] out_count_q;

	// rectangle memory
	logic [RW-1:0]   mem [CAPACITY];
	logic [RW-1:0]   rdata;
	logic [IW-1:0]   raddr, waddr;
	logic [RW-1:0]   wdata;
	logic            we;

	// evaluation pipeline
	eval_t           ev;
	logic [CW-1:0]   ev_idx;
	logic [RW-1:0]   ev_uni;

	logic            accept, scan_rd, shift_rd, ev_hit, ev_miss, ev_stop;
	logic            shift_done, rsp_free, store_full;

	assign req_ready  = (state_q == S_IDLE);
	assign accept     = req_valid && req_ready;
	assign store_full = (count_q >= CW'(CAPACITY));
	assign rsp_free   = !rsp_valid_q || rsp_ready;

	// scan stops at the first qualifying entry, or after the last entry
	assign ev_hit   = (state_q == S_SCAN) && ev.valid && ev.hit;
	assign ev_miss  = (state_q == S_SCAN) && ev.valid && !ev.hit
		&& (ev_idx == count_q - CW'(1));
	assign ev_stop  = ev_hit || ev_miss;
	assign scan_rd  = (state_q == S_SCAN) && (ptr_q < count_q) && !ev_stop;
	assign shift_rd = (state_q == S_SHIFT) && (ptr_q < count_q);
	// all moves written, merged box goes to the tail
	assign shift_done = (state_q == S_SHIFT) && !shift_rd && !wv_s1;

	// read address: head for a get, running index otherwise
	always_comb begin
		if (state_q == S_GET_RD) begin
			raddr = head_q;
		end else begin
			raddr = phys(head_q, ptr_q);
		end
	end

	// single write port: close-up moves, merged box, or plain append
	always_comb begin
		we    = 1'b0;
		waddr = phys(head_q, count_q);
		wdata = nw_q;
		priority if ((state_q == S_SHIFT) && wv_s1) begin
			we    = 1'b1;
			waddr = wa_s1;
			wdata = rdata;
		end else if (shift_done) begin
			we    = 1'b1;
			waddr = phys(head_q, count_q - CW'(1));
			wdata = uni_q;
		end else if ((state_q == S_APPEND) && !store_full) begin
			we    = 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

	dcq_eval #(
		.COORD_BITS (COORD_BITS),
		.IDX_BITS   (CW)
	) u_eval (
		.clk      (clk),
		.arst_n   (arst_n),
		.flush    (ev_stop),
		.rd_valid (rdv_s1),
		.rd_idx   (ridx_s1),
		.entry    (rdata),
		.nw       (nw_q),
		.ev       (ev),
		.ev_idx   (ev_idx),
		.ev_uni   (ev_uni)
	);

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			count_q     <= '0;
			head_q      <= '0;
			ptr_q       <= '0;
			rdv_s1      <= 1'b0;
			wv_s1       <= 1'b0;
			rsp_valid_q <= 1'b0;
		end else begin
			rdv_s1 <= scan_rd;
			wv_s1  <= shift_rd;
			// result register loads when free, empties when taken
			if ((state_q == S_FINISH) && rsp_free) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp_ready) begin
				rsp_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					ptr_q <= '0;
					if (accept) begin
						priority if (mode == MODE_GET) begin
							state_q <= (count_q == '0) ? S_FINISH : S_GET_RD;
						end else begin
							state_q <= (count_q == '0) ? S_APPEND : S_SCAN;
						end
					end
				end
				S_GET_RD: begin
					state_q <= S_GET_WB;
				end
				S_GET_WB: begin
					// pop the oldest entry by moving the ring head
					head_q  <= (head_q == IW'(CAPACITY - 1)) ? '0 : head_q + IW'(1);
					count_q <= count_q - CW'(1);
					state_q <= S_FINISH;
				end
				S_SCAN: begin
					priority if (ev_hit) begin
						ptr_q   <= ev_idx + CW'(1);
						state_q <= S_SHIFT;
					end else if (ev_miss) begin
						state_q <= S_APPEND;
					end else if (scan_rd) begin
						ptr_q <= ptr_q + CW'(1);
					end
				end
				S_SHIFT: begin
					if (shift_rd) begin
						ptr_q <= ptr_q + CW'(1);
					end
					if (shift_done) begin
						state_q <= S_FINISH;
					end
				end
				S_APPEND: begin
					if (!store_full) begin
						count_q <= count_q + CW'(1);
					end
					state_q <= S_FINISH;
				end
				S_FINISH: begin
					if (rsp_free) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		ridx_s1 <= ptr_q;
		wa_s1   <= phys(head_q, ptr_q - CW'(1));
		if (accept) begin
			nw_q          <= {in_bottom, in_right, in_top, in_left};
			res_rect_q    <= '0;
			res_empty_q   <= (mode == MODE_GET) && (count_q == '0);
			res_merged_q  <= 1'b0;
			res_dropped_q <= 1'b0;
		end
		if (state_q == S_GET_WB) begin
			res_rect_q <= rdata;
		end
		if (ev_hit) begin
			uni_q <= ev_uni;
		end
		if (shift_done) begin
			res_merged_q <= 1'b1;
		end
		if (state_q == S_APPEND) begin
			res_dropped_q <= store_full;
		end
		if ((state_q == S_FINISH) && rsp_free) begin
			out_rect_q    <= res_rect_q;
			out_empty_q   <= res_empty_q;
			out_merged_q  <= res_merged_q;
			out_dropped_q <= res_dropped_q;
			out_count_q   <= COUNT_OUT_BITS'(count_q);
		end
	end

	assign rsp_valid   = rsp_valid_q;
	assign out_left    = out_rect_q[CB-1:0];
	assign out_top     = out_rect_q[2*CB-1:CB];
	assign out_right   = out_rect_q[3*CB-1:2*CB];
	assign out_bottom  = out_rect_q[4*CB-1:3*CB];
	assign was_empty   = out_empty_q;
	assign merged      = out_merged_q;
	assign dropped     = out_dropped_q;
	assign entry_count = out_count_q;

endmodule

[hdl/dcq_eval.sv]
module dcq_eval #(
	parameter int COORD_BITS = dcq_pkg::COORD_BITS_DEF,
	parameter int IDX_BITS   = 5
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    flush,
	input  logic                    rd_valid,
	input  logic [IDX_BITS-1:0]     rd_idx,
	input  logic [4*COORD_BITS-1:0] entry,
	input  logic [4*COORD_BITS-1:0] nw,
	output dcq_pkg::eval_t          ev,
	output logic [IDX_BITS-1:0]     ev_idx,
	output logic [4*COORD_BITS-1:0] ev_uni
);
	import dcq_pkg::*;

	localparam int CB = COORD_BITS;
	localparam int DW = CB + 1;
	localparam int SW = (DW > 32) ? 32 : DW;
	localparam int PW = 2 * SW;
	localparam logic signed [DW-1:0] LIM_D  = DW'((64'sd1 <<< (SW - 1)) - 64'sd1);
	localparam logic signed [DW-1:0] NLIM_D = -LIM_D;

	// exact side length, saturated to the multiplier width
	function automatic logic signed [SW-1:0] side(input logic [CB-1:0] lo,
		input logic [CB-1:0] hi);
		logic signed [DW-1:0] d;
		begin
			d = $signed({hi[CB-1], hi}) - $signed({lo[CB-1], lo});
			if (d > LIM_D) begin
				d = LIM_D;
			end else if (d < NLIM_D) begin
				d = NLIM_D;
			end
			return d[SW-1:0];
		end
	endfunction

	logic signed [CB-1:0] el, et, er, eb, nl, nt, nr, nb;
	logic signed [CB-1:0] ul, ut, ur, ub;
	logic                 e_empty, n_empty;

	assign el = entry[CB-1:0];
	assign et = entry[2*CB-1:CB];
	assign er = entry[3*CB-1:2*CB];
	assign eb = entry[4*CB-1:3*CB];
	assign nl = nw[CB-1:0];
	assign nt = nw[2*CB-1:CB];
	assign nr = nw[3*CB-1:2*CB];
	assign nb = nw[4*CB-1:3*CB];

	assign e_empty = (er <= el) || (eb <= et);
	assign n_empty = (nr <= nl) || (nb <= nt);

	// bounding box of stored entry and new rectangle
	always_comb begin
		priority if (e_empty && n_empty) begin
			ul = '0; ut = '0; ur = '0; ub = '0;
		end else if (e_empty) begin
			ul = nl; ut = nt; ur = nr; ub = nb;
		end else if (n_empty) begin
			ul = el; ut = et; ur = er; ub = eb;
		end else begin
			ul = (el < nl) ? el : nl;
			ut = (et < nt) ? et : nt;
			ur = (er > nr) ? er : nr;
			ub = (eb > nb) ? eb : nb;
		end
	end

	// stage 2: box and sides
	logic                    v_s2;
	logic [IDX_BITS-1:0]     idx_s2;
	logic [4*CB-1:0]         uni_s2;
	logic signed [SW-1:0]    uw_s2, uh_s2, ew_s2, eh_s2;
	// stage 3: areas
	logic                    v_s3;
	logic [IDX_BITS-1:0]     idx_s3;
	logic [4*CB-1:0]         uni_s3;
	logic signed [PW-1:0]    ua_s3, ea_s3;
	// area of the new rectangle, held while it is stable
	logic signed [PW-1:0]    anw_q;
	logic signed [SW-1:0]    nw_w, nw_h;

	assign nw_w = side(nw[CB-1:0], nw[3*CB-1:2*CB]);
	assign nw_h = side(nw[2*CB-1:CB], nw[4*CB-1:3*CB]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else begin
			v_s2 <= rd_valid && !flush;
			v_s3 <= v_s2 && !flush;
		end
	end

	always_ff @(posedge clk) begin
		anw_q  <= nw_w * nw_h;
		idx_s2 <= rd_idx;
		uni_s2 <= {ub, ur, ut, ul};
		uw_s2  <= side(ul, ur);
		uh_s2  <= side(ut, ub);
		ew_s2  <= side(el, er);
		eh_s2  <= side(et, eb);
		idx_s3 <= idx_s2;
		uni_s3 <= uni_s2;
		ua_s3  <= uw_s2 * uh_s2;
		ea_s3  <= ew_s2 * eh_s2;
	end

	logic signed [PW:0] sum_s3;
	assign sum_s3 = $signed({ea_s3[PW-1], ea_s3}) + $signed({anw_q[PW-1], anw_q});

	assign ev.valid = v_s3;
	assign ev.hit   = $signed({ua_s3[PW-1], ua_s3}) <= sum_s3;
	assign ev_idx   = idx_s3;
	assign ev_uni   = uni_s3;

endmodule

[verif/tb_dirty_rect_coalescing_queue.sv]
module tb_dirty_rect_coalescing_queue;
	timeunit 1ns;
	timeprecision 1ps;

	import dcq_pkg::*;

	localparam int CW           = COORD_BITS_DEF;
	localparam int DEPTH        = CAPACITY_DEF;
	localparam int N_PHASES     = 22;
	localparam int PHASE_ITEMS  = 60;
	// long enough for the block to fill its result register and stall requests
	localparam int LONG_HOLD    = 300;
	// a full scan of the store plus a close-up, with margin
	localparam int TAIL_CYCLES  = 40;
	localparam int RUN_LIMIT_NS = 1_000_000;
	localparam int PRINT_CAP    = 100;

	typedef logic signed [CW-1:0] coord_t;

	typedef struct {
		coord_t l, t, r, b;
	} rect_t;

	typedef struct {
		rect_t                     box;
		logic                      was_empty;
		logic                      merged;
		logic                      dropped;
		logic [COUNT_OUT_BITS-1:0] count;
	} result_t;

	// predicted store of dirty rectangles and the results still to come back
	class coalesce_scoreboard;
		rect_t   held[$];
		result_t awaited[$];
		int      errors;

		// width times height, negative for some empty rectangles; exact at these widths
		function longint area_of(rect_t a);
			return (longint'(a.r) - longint'(a.l)) * (longint'(a.b) - longint'(a.t));
		endfunction

		function bit is_void(rect_t a);
			return (a.r <= a.l) || (a.b <= a.t);
		endfunction

		function rect_t bound(rect_t a, rect_t b);
			rect_t u;
			if (is_void(a) && is_void(b)) begin
				u = '{default: '0};
			end else if (is_void(a)) begin
				u = b;
			end else if (is_void(b)) begin
				u = a;
			end else begin
				u.l = (a.l < b.l) ? a.l : b.l;
				u.t = (a.t < b.t) ? a.t : b.t;
				u.r = (a.r > b.r) ? a.r : b.r;
				u.b = (a.b > b.b) ? a.b : b.b;
			end
			return u;
		endfunction

		function void apply_request(logic m, rect_t nw);
			result_t res;
			rect_t   u;
			bit      hit;
			res.box       = '{default: '0};
			res.was_empty = 1'b0;
			res.merged    = 1'b0;
			res.dropped   = 1'b0;
			hit           = 1'b0;
			if (m == MODE_GET) begin
				if (held.size() == 0)
					res.was_empty = 1'b1;
				else
					res.box = held.pop_front();
			end else begin
				// first entry, oldest first, whose bounding box costs no extra area
				for (int j = 0; j < held.size(); j++) begin
					u = bound(held[j], nw);
					if (area_of(u) <= area_of(held[j]) + area_of(nw)) begin
						held.delete(j);
						held.push_back(u);
						hit = 1'b1;
						break;
					end
				end
				if (hit)
					res.merged = 1'b1;
				else if (held.size() >= DEPTH)
					res.dropped = 1'b1;
				else
					held.push_back(nw);
			end
			res.count = COUNT_OUT_BITS'(held.size());
			awaited.push_back(res);
		endfunction

		// one line per mismatch, printing capped so a broken block cannot flood the log
		task report(string msg);
			if (errors < PRINT_CAP)
				$display("mismatch at %0t ns: %s", $time, msg);
			errors++;
		endtask

		task check_response(result_t got);
			result_t want;
			if (awaited.size() == 0) begin
				report("result with no request outstanding");
				return;
			end
			want = awaited.pop_front();
			if (got.box.l !== want.box.l)
				report($sformatf("out_left %0d, expected %0d", got.box.l, want.box.l));
			if (got.box.t !== want.box.t)
				report($sformatf("out_top %0d, expected %0d", got.box.t, want.box.t));
			if (got.box.r !== want.box.r)
				report($sformatf("out_right %0d, expected %0d", got.box.r, want.box.r));
			if (got.box.b !== want.box.b)
				report($sformatf("out_bottom %0d, expected %0d", got.box.b, want.box.b));
			if (got.was_empty !== want.was_empty)
				report($sformatf("was_empty %b, expected %b", got.was_empty, want.was_empty));
			if (got.merged !== want.merged)
				report($sformatf("merged %b, expected %b", got.merged, want.merged));
			if (got.dropped !== want.dropped)
				report($sformatf("dropped %b, expected %b", got.dropped, want.dropped));
			if (got.count !== want.count)
				report($sformatf("entry_count %0d, expected %0d", got.count, want.count));
		endtask
	endclass

	logic                      clk;
	logic                      arst_n;
	logic                      req_valid;
	logic                      req_ready;
	logic                      mode;
	coord_t                    in_left, in_top, in_right, in_bottom;
	logic                      rsp_valid;
	logic                      rsp_ready;
	coord_t                    out_left, out_top, out_right, out_bottom;
	logic                      was_empty;
	logic                      merged;
	logic                      dropped;
	logic [COUNT_OUT_BITS-1:0] entry_count;

	coalesce_scoreboard sb = new();
	result_t            seen;

	// receiver behaviour, set per phase by the stimulus process
	logic [7:0] ready_pat = 8'hFF;
	int         pat_len   = 8;
	int         hold_asked  = 0;
	int         hold_served = 0;

	dirty_rect_coalescing_queue DUT (.*);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	// hard stop in case the block hangs
	initial begin
		#(RUN_LIMIT_NS);
		$display("CHECKS FAILED");
		$finish;
	end

	function automatic rect_t rect_of(int l, int t, int r, int b);
		rect_t rc;
		rc.l = coord_t'(l);
		rc.t = coord_t'(t);
		rc.r = coord_t'(r);
		rc.b = coord_t'(b);
		return rc;
	endfunction

	function automatic coord_t extreme_coord();
		case ($urandom_range(0, 4))
			0: return coord_t'(-32768);
			1: return coord_t'(-1);
			2: return coord_t'(0);
			3: return coord_t'(1);
			default: return coord_t'(32767);
		endcase
	endfunction

	// local_pct steers how many rectangles land in a small shared area and so merge
	function automatic rect_t rand_rect(int local_pct);
		rect_t rc;
		int    v;
		v = $urandom_range(0, 99);
		if (v < local_pct) begin
			// crowded corner, merges are common
			rc.l = coord_t'($urandom_range(0, 60));
			rc.t = coord_t'($urandom_range(0, 60));
			rc.r = rc.l + coord_t'($urandom_range(1, 24));
			rc.b = rc.t + coord_t'($urandom_range(1, 24));
		end else if (v < local_pct + 10) begin
			// empty rectangles: zero or negative width, height or both
			rc.l = coord_t'($urandom_range(0, 200)) - coord_t'(100);
			rc.t = coord_t'($urandom_range(0, 200)) - coord_t'(100);
			case ($urandom_range(0, 2))
				0: begin
					rc.r = rc.l - coord_t'($urandom_range(0, 20));
					rc.b = rc.t + coord_t'($urandom_range(1, 20));
				end
				1: begin
					rc.r = rc.l + coord_t'($urandom_range(1, 20));
					rc.b = rc.t - coord_t'($urandom_range(0, 20));
				end
				default: begin
					rc.r = rc.l - coord_t'($urandom_range(0, 20));
					rc.b = rc.t - coord_t'($urandom_range(0, 20));
				end
			endcase
		end else if (v < local_pct + 15) begin
			rc.l = coord_t'($urandom);
			rc.t = coord_t'($urandom);
			rc.r = coord_t'($urandom);
			rc.b = coord_t'($urandom);
		end else if (v < local_pct + 18) begin
			rc.l = extreme_coord();
			rc.t = extreme_coord();
			rc.r = extreme_coord();
			rc.b = extreme_coord();
		end else begin
			// small rectangle anywhere, rarely merges, so the store fills up
			rc.l = coord_t'($urandom);
			rc.t = coord_t'($urandom);
			rc.r = rc.l + coord_t'($urandom_range(1, 64));
			rc.b = rc.t + coord_t'($urandom_range(1, 64));
		end
		return rc;
	endfunction

	// called at a falling edge, returns at the falling edge after acceptance
	task automatic send_item(logic m, rect_t rc);
		req_valid = 1'b1;
		mode      = m;
		in_left   = rc.l;
		in_top    = rc.t;
		in_right  = rc.r;
		in_bottom = rc.b;
		do @(posedge clk); while (!req_ready);
		sb.apply_request(m, rc);
		@(negedge clk);
	endtask

	task automatic wait_drained();
		while (sb.awaited.size() != 0)
			@(negedge clk);
	endtask

	// result monitor, sampled at the rising edge
	always @(posedge clk) begin
		if (arst_n && rsp_valid && rsp_ready) begin
			seen.box.l     = out_left;
			seen.box.t     = out_top;
			seen.box.r     = out_right;
			seen.box.b     = out_bottom;
			seen.was_empty = was_empty;
			seen.merged    = merged;
			seen.dropped   = dropped;
			seen.count     = entry_count;
			sb.check_response(seen);
		end
	end

	// receiver: rotating ready pattern, or a long hold-off on request
	initial begin
		int hold_left;
		int bit_idx;
		hold_left = 0;
		bit_idx   = 0;
		rsp_ready = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_served != hold_asked) begin
				hold_served = hold_asked;
				hold_left   = LONG_HOLD;
			end
			if (hold_left > 0) begin
				rsp_ready = 1'b0;
				hold_left--;
			end else begin
				rsp_ready = ready_pat[bit_idx % 8];
				bit_idx   = (bit_idx + 1) % pat_len;
			end
		end
	end

	// stimulus
	initial begin
		int   add_pct;
		int   local_pct;
		int   max_gap;
		int   burst_left;
		int   gap;
		logic m;
		rect_t blank;

		blank     = '{default: '0};
		req_valid = 1'b0;
		mode      = MODE_ADD;
		in_left   = '0;
		in_top    = '0;
		in_right  = '0;
		in_bottom = '0;
		arst_n    = 1'b0;
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// get on an empty store
		send_item(MODE_GET, blank);
		// whole coordinate range, then a rectangle inside it merges
		send_item(MODE_ADD, rect_of(-32768, -32768, 32767, 32767));
		send_item(MODE_ADD, rect_of(0, 0, 10, 10));
		send_item(MODE_GET, blank);
		// two empty rectangles whose areas cancel: merge gives an all-zero box
		send_item(MODE_ADD, rect_of(30, 0, 20, 10));
		send_item(MODE_ADD, rect_of(20, 20, 10, 10));
		send_item(MODE_GET, blank);
		// side by side: bounding box area equals the sum exactly
		send_item(MODE_ADD, rect_of(0, 0, 10, 10));
		send_item(MODE_ADD, rect_of(10, 0, 20, 10));
		// empty with negative area does not merge with the stored box, so it is stored
		send_item(MODE_ADD, rect_of(30, 0, 20, 10));
		// zero width merges into the head, which moves to the tail
		send_item(MODE_ADD, rect_of(5, 5, 5, 20));
		send_item(MODE_GET, blank);
		send_item(MODE_GET, blank);
		// fill with rectangles on a diagonal, none of which merge
		for (int i = 0; i < DEPTH; i++)
			send_item(MODE_ADD, rect_of(i * 100, i * 100, i * 100 + 10, i * 100 + 10));
		// full store: no match drops, a match still goes in with the count unchanged
		send_item(MODE_ADD, rect_of(3000, 3000, 3010, 3010));
		send_item(MODE_ADD, rect_of(0, 0, 5, 5));

		for (int p = 0; p < N_PHASES; p++) begin
			case ($urandom_range(0, 3))
				0: add_pct = 40;
				1: add_pct = 60;
				2: add_pct = 75;
				default: add_pct = 90;
			endcase
			case ($urandom_range(0, 2))
				0: local_pct = 5;
				1: local_pct = 35;
				default: local_pct = 70;
			endcase
			max_gap = (p % 3 == 0) ? 0 : $urandom_range(1, 8);
			if ($urandom_range(0, 3) == 0) begin
				ready_pat = 8'hFF;
			end else begin
				ready_pat    = 8'($urandom);
				ready_pat[0] = 1'b1;
			end
			pat_len = $urandom_range(3, 8);
			// receiver holds off while requests keep coming
			if (p == 4 || p == 15) begin
				hold_asked++;
				max_gap = 0;
			end
			burst_left = 0;
			for (int n = 0; n < PHASE_ITEMS; n++) begin
				if (burst_left == 0) begin
					gap = $urandom_range(0, max_gap);
					if (gap > 0) begin
						req_valid = 1'b0;
						repeat (gap) @(negedge clk);
					end
					burst_left = $urandom_range(1, 12);
				end
				burst_left--;
				m = ($urandom_range(0, 99) < add_pct) ? MODE_ADD : MODE_GET;
				send_item(m, rand_rect(local_pct));
			end
			// sender waits for every outstanding result now and then
			if (p % 4 == 3 || $urandom_range(0, 5) == 0) begin
				req_valid = 1'b0;
				wait_drained();
			end
		end

		req_valid = 1'b0;
		wait_drained();
		repeat (TAIL_CYCLES) @(negedge clk);
		if (sb.errors == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

endmodule
